// ===== sv/twn_pkg.sv =====
// Package for the text whitespace normalizer.
// Holds byte codes, queue sizes and the command type passed from front to back.
// Depends on nothing.
package twn_pkg;

  // Byte codes that the normalizer treats specially.
  localparam logic [7:0] LINE_FEED       = 8'd10;
  localparam logic [7:0] CARRIAGE_RETURN = 8'd13;
  localparam logic [7:0] SPACE_CHAR      = 8'd32;

  // Trailing-trim store size and derived widths.
  localparam int PENDING_DEPTH = 32;
  localparam int PEND_PTR_W    = $clog2(PENDING_DEPTH);
  localparam int PEND_CNT_W    = $clog2(PENDING_DEPTH + 1);

  // Command queue between front and back.
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // One unit of work for the back end: an end marker, or a byte to keep,
  // optionally preceded by an owed space.
  typedef struct packed {
    logic       is_end;
    logic       space_first;
    logic [7:0] data;
  } twn_cmd_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } twn_q_stat_t;

endpackage

// ===== sv/twn_if.sv =====
// Channel interfaces for the text whitespace normalizer.
// Input requests carry raw bytes; output requests carry normalized results.
// Depends on nothing.
interface twn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface twn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       is_last;
  logic       trim_overflow;

  modport source (output valid, out_byte, has_byte, is_last, trim_overflow, input ready);
  modport sink   (input valid, out_byte, has_byte, is_last, trim_overflow, output ready);
endinterface

// ===== sv/text_whitespace_normalizer_core.sv =====
// Channel    Dir  Payload                                   Handshake
// in_chan    in   text_byte[7:0], end_of_text               valid / ready
// out_chan   out  out_byte[7:0], has_byte, is_last,         valid / ready
//                 trim_overflow
//
// The front end takes one request per cycle while its command queue has room.
// The back end handles each kept byte or end marker in turn, puts an owed space
// first, and flushes held bytes one at a time ahead of a data byte.
// Reset (rst_n, synchronous, active low) clears all control state at once;
// the held-byte store is not cleared, since only entries below the count are read.
// A stalled output holds the back end; a full command queue holds the input.
//
// Top level of the text whitespace normalizer.
// Depends on twn_pkg, twn_if, twn_front, twn_cmd_fifo and twn_back.
module text_whitespace_normalizer_core
  import twn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  twn_in_if.sink     in_chan,
  twn_out_if.source  out_chan
);

  logic        cmd_push, cmd_pop;
  twn_cmd_t    push_cmd, head_cmd;
  twn_q_stat_t q_stat;

  // Classify incoming bytes.
  twn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_stat   (q_stat),
    .cmd_push (cmd_push),
    .cmd      (push_cmd)
  );

  // Commands waiting for the back end.
  twn_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  // Trim, flush and emit results.
  twn_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .q_stat   (q_stat),
    .cmd_pop  (cmd_pop),
    .out_chan (out_chan)
  );

  // The queue is never pushed while full.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !q_stat.full)
    else $error("command pushed into a full queue");

  // The queue is never popped while empty.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !q_stat.empty)
    else $error("command popped from an empty queue");

  // An end marker carries no byte.
  a_end_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.is_last) |-> (!out_chan.has_byte && out_chan.out_byte == 8'd0))
    else $error("end marker carries a byte");

  // Overflow is only reported on the end marker.
  a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.is_last) |-> !out_chan.trim_overflow)
    else $error("overflow flag on a byte result");

endmodule

// ===== sv/twn_front.sv =====
// Front end: accepts raw bytes, tracks line-break state and issues commands.
// Depends on twn_pkg and twn_if.
module twn_front
  import twn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  twn_in_if.sink      in_chan,
  input  twn_q_stat_t q_stat,
  output logic        cmd_push,
  output twn_cmd_t    cmd
);

  logic       space_owed_r, space_owed_nxt;
  logic       after_return_r, after_return_nxt;
  logic       seen_data_r, seen_data_nxt;
  logic [1:0] newline_run_r, newline_run_nxt;
  logic       accept;
  logic       want_push;

  // A request is taken whenever the command queue has room.
  assign in_chan.ready = !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign cmd_push      = accept && want_push;

  // Classify the byte and work out the next line-break state.
  always_comb begin
    space_owed_nxt   = space_owed_r;
    after_return_nxt = after_return_r;
    seen_data_nxt    = seen_data_r;
    newline_run_nxt  = newline_run_r;
    want_push        = 1'b0;
    cmd.is_end       = 1'b0;
    cmd.space_first  = 1'b0;
    cmd.data         = in_chan.text_byte;
    if (in_chan.end_of_text) begin
      want_push        = 1'b1;
      cmd.is_end       = 1'b1;
      cmd.data         = 8'd0;
      space_owed_nxt   = 1'b0;
      after_return_nxt = 1'b0;
      seen_data_nxt    = 1'b0;
      newline_run_nxt  = 2'd0;
    end else if (in_chan.text_byte == LINE_FEED) begin
      if (seen_data_r) begin
        space_owed_nxt   = !after_return_r;
        after_return_nxt = 1'b0;
        if (newline_run_r != 2'd2) begin
          newline_run_nxt = newline_run_r + 2'd1;
        end
        // Second and later line feeds of a run are kept.
        want_push = (newline_run_r != 2'd0);
      end
    end else if (in_chan.text_byte == CARRIAGE_RETURN) begin
      if (seen_data_r) begin
        want_push        = 1'b1;
        cmd.data         = LINE_FEED;
        space_owed_nxt   = 1'b0;
        after_return_nxt = 1'b1;
      end
    end else begin
      want_push       = 1'b1;
      seen_data_nxt   = 1'b1;
      newline_run_nxt = 2'd0;
      space_owed_nxt  = 1'b0;
      cmd.space_first = space_owed_r && (in_chan.text_byte != SPACE_CHAR);
    end
  end

  // State advances only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_owed_r   <= 1'b0;
      after_return_r <= 1'b0;
      seen_data_r    <= 1'b0;
      newline_run_r  <= 2'd0;
    end else if (accept) begin
      space_owed_r   <= space_owed_nxt;
      after_return_r <= after_return_nxt;
      seen_data_r    <= seen_data_nxt;
      newline_run_r  <= newline_run_nxt;
    end
  end

endmodule

// ===== sv/twn_cmd_fifo.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on twn_pkg.
module twn_cmd_fifo
  import twn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  twn_cmd_t    push_cmd,
  input  logic        pop,
  output twn_cmd_t    head_cmd,
  output twn_q_stat_t stat
);

  twn_cmd_t              slots_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, wr_ptr_r;
  logic [CMDQ_CNT_W-1:0] count_r;
  logic                  do_push, do_pop;

  assign stat.full  = (count_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_cmd   = slots_r[rd_ptr_r];

  // Pointer step with wrap at the queue depth.
  function automatic logic [CMDQ_PTR_W-1:0] step_ptr(input logic [CMDQ_PTR_W-1:0] p);
    step_ptr = (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= step_ptr(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= step_ptr(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/twn_back.sv =====
// Back end: runs commands through the trailing-trim store and drives results.
// Depends on twn_pkg and twn_if.
module twn_back
  import twn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  twn_cmd_t    head_cmd,
  input  twn_q_stat_t q_stat,
  output logic        cmd_pop,
  twn_out_if.source   out_chan
);

  // Command being worked on.
  logic                  busy_r;
  logic                  cur_end_r;
  logic                  cur_space_r;
  logic [7:0]            cur_byte_r;

  // Trailing-trim store: 1 = line feed, 0 = space. Circular, oldest at head.
  logic [PENDING_DEPTH-1:0] pend_r;
  logic [PEND_PTR_W-1:0]    head_r, tail_r;
  logic [PEND_CNT_W-1:0]    count_r;
  logic                     emitted_any_r;
  logic                     overflow_r;

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_has_r, out_last_r, out_ovf_r;

  logic       out_can;
  logic [7:0] step_byte;
  logic       trimmable, full;
  logic       emit, pend_push, pend_pop, set_ovf, mark_emitted, clear_all, step_done;
  logic       advance, finish;
  logic [7:0] emit_byte;
  logic       emit_has, emit_last;
  logic [7:0] oldest_byte;

  function automatic logic [PEND_PTR_W-1:0] step_ptr(input logic [PEND_PTR_W-1:0] p);
    step_ptr = (p == PEND_PTR_W'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_can     = !out_valid_r || out_chan.ready;
  assign step_byte   = cur_space_r ? SPACE_CHAR : cur_byte_r;
  assign trimmable   = (step_byte == LINE_FEED) || (step_byte == SPACE_CHAR);
  assign full        = (count_r == PEND_CNT_W'(PENDING_DEPTH));
  assign oldest_byte = pend_r[head_r] ? LINE_FEED : SPACE_CHAR;

  // Decide what the current step does this cycle.
  always_comb begin
    emit         = 1'b0;
    emit_byte    = step_byte;
    emit_has     = 1'b1;
    emit_last    = 1'b0;
    pend_push    = 1'b0;
    pend_pop     = 1'b0;
    set_ovf      = 1'b0;
    mark_emitted = 1'b0;
    clear_all    = 1'b0;
    step_done    = 1'b0;
    if (busy_r) begin
      if (cur_end_r) begin
        // End marker: report overflow and drop whatever is held.
        emit      = 1'b1;
        emit_byte = 8'd0;
        emit_has  = 1'b0;
        emit_last = 1'b1;
        clear_all = 1'b1;
        step_done = 1'b1;
      end else if (trimmable && emitted_any_r) begin
        // Hold the byte; a full store gives up its oldest entry.
        pend_push = 1'b1;
        step_done = 1'b1;
        if (full) begin
          emit      = 1'b1;
          emit_byte = oldest_byte;
          pend_pop  = 1'b1;
          set_ovf   = 1'b1;
        end
      end else if (!trimmable && (count_r != '0)) begin
        // Flush held bytes one per cycle before a kept byte, while the output is not stalled.
        emit      = 1'b1;
        emit_byte = oldest_byte;
        pend_pop  = 1'b1;
      end else begin
        emit         = 1'b1;
        mark_emitted = 1'b1;
        step_done    = 1'b1;
      end
    end
  end

  assign advance = !emit || out_can;
  assign finish  = advance && step_done && !cur_space_r;
  assign cmd_pop = (!busy_r || finish) && !q_stat.empty;

  // Held-byte storage needs no reset.
  always_ff @(posedge clk) begin
    if (advance && pend_push) begin
      pend_r[tail_r] <= (step_byte == LINE_FEED);
    end
  end

  // Command registers and trim-store control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      cur_end_r     <= 1'b0;
      cur_space_r   <= 1'b0;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
      emitted_any_r <= 1'b0;
      overflow_r    <= 1'b0;
    end else begin
      if (cmd_pop) begin
        busy_r      <= 1'b1;
        cur_end_r   <= head_cmd.is_end;
        cur_space_r <= head_cmd.space_first;
      end else if (finish) begin
        busy_r <= 1'b0;
      end else if (advance && step_done) begin
        cur_space_r <= 1'b0;
      end
      if (advance) begin
        if (clear_all) begin
          head_r        <= '0;
          tail_r        <= '0;
          count_r       <= '0;
          emitted_any_r <= 1'b0;
          overflow_r    <= 1'b0;
        end else begin
          if (pend_push) begin
            tail_r <= step_ptr(tail_r);
          end
          if (pend_pop) begin
            head_r <= step_ptr(head_r);
          end
          if (pend_push && !pend_pop) begin
            count_r <= count_r + 1'b1;
          end else if (pend_pop && !pend_push) begin
            count_r <= count_r - 1'b1;
          end
          if (set_ovf) begin
            overflow_r <= 1'b1;
          end
          if (mark_emitted) begin
            emitted_any_r <= 1'b1;
          end
        end
      end
    end
  end

  // Command byte is payload only.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_byte_r <= head_cmd.data;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && out_can) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit && out_can) begin
      out_byte_r <= emit_byte;
      out_has_r  <= emit_has;
      out_last_r <= emit_last;
      out_ovf_r  <= emit_last && overflow_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_byte      = out_byte_r;
  assign out_chan.has_byte      = out_has_r;
  assign out_chan.is_last       = out_last_r;
  assign out_chan.trim_overflow = out_ovf_r;

endmodule

// ===== bench/twn_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the text whitespace normalizer bench: predicts every result from the
// accepted input requests and compares it with what leaves the output channel.
// Depends on twn_pkg and the twn_in_if / twn_out_if interfaces.
module twn_checker
  import twn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  twn_in_if    in_mon,
  twn_out_if   out_mon,
  output int   fail_count,
  output int   results_owed
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       is_last;
    logic       trim_overflow;
  } norm_result_t;

  // Results still to come, oldest first.
  norm_result_t expected_q[$];

  // Predicted line-break and trim state of the current text.
  logic       owe_space;
  logic       cr_last;
  logic       text_started;
  logic [1:0] lf_run;
  logic       out_started;
  logic       held_is_lf [PENDING_DEPTH];
  int         held_cnt;
  logic       held_overflow;

  assign results_owed = expected_q.size();

  function automatic void push_byte(input logic [7:0] b);
    norm_result_t r;
    r.out_byte      = b;
    r.has_byte      = 1'b1;
    r.is_last       = 1'b0;
    r.trim_overflow = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void clear_text_state();
    owe_space     = 1'b0;
    cr_last       = 1'b0;
    text_started  = 1'b0;
    lf_run        = 2'd0;
    out_started   = 1'b0;
    held_cnt      = 0;
    held_overflow = 1'b0;
  endfunction

  // Line feeds and spaces wait in the trim store until a data byte follows; on a
  // full store the oldest one goes out early. Nothing is held at output position zero.
  function automatic void keep_or_hold(input logic [7:0] b);
    logic trimmable;
    trimmable = (b == LINE_FEED) || (b == SPACE_CHAR);
    if (trimmable && out_started) begin
      if (held_cnt >= PENDING_DEPTH) begin
        push_byte(held_is_lf[0] ? LINE_FEED : SPACE_CHAR);
        for (int i = 0; i < PENDING_DEPTH - 1; i++) held_is_lf[i] = held_is_lf[i + 1];
        held_cnt      = PENDING_DEPTH - 1;
        held_overflow = 1'b1;
      end
      held_is_lf[held_cnt] = (b == LINE_FEED);
      held_cnt++;
    end else begin
      if (!trimmable) begin
        for (int i = 0; i < held_cnt; i++) push_byte(held_is_lf[i] ? LINE_FEED : SPACE_CHAR);
        held_cnt = 0;
      end
      push_byte(b);
      out_started = 1'b1;
    end
  endfunction

  // Expected results of one accepted input request.
  function automatic void predict_request(input logic [7:0] b, input logic eot);
    norm_result_t r;
    if (eot) begin
      r.out_byte      = 8'h00;
      r.has_byte      = 1'b0;
      r.is_last       = 1'b1;
      r.trim_overflow = held_overflow;
      expected_q.push_back(r);
      clear_text_state();
    end else if (b == LINE_FEED) begin
      if (text_started) begin
        owe_space = !cr_last;
        cr_last   = 1'b0;
        if (lf_run < 2'd2) lf_run = lf_run + 2'd1;
        if (lf_run == 2'd2) keep_or_hold(LINE_FEED);
      end
    end else if (b == CARRIAGE_RETURN) begin
      if (text_started) begin
        keep_or_hold(LINE_FEED);
        owe_space = 1'b0;
        cr_last   = 1'b1;
      end
    end else begin
      text_started = 1'b1;
      lf_run       = 2'd0;
      if (owe_space) begin
        owe_space = 1'b0;
        if (b != SPACE_CHAR) keep_or_hold(SPACE_CHAR);
      end
      keep_or_hold(b);
    end
  endfunction

  // Both channels are sampled at the rising edge; a request is predicted before
  // any result of the same edge is compared.
  always @(posedge clk) begin
    norm_result_t seen;
    norm_result_t want;
    if (!rst_n) begin
      clear_text_state();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) predict_request(in_mon.text_byte, in_mon.end_of_text);
      if (out_mon.valid && out_mon.ready) begin
        seen.out_byte      = out_mon.out_byte;
        seen.has_byte      = out_mon.has_byte;
        seen.is_last       = out_mon.is_last;
        seen.trim_overflow = out_mon.trim_overflow;
        if (expected_q.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t: unexpected result byte=%h has=%b last=%b ovf=%b", $realtime,
                     seen.out_byte, seen.has_byte, seen.is_last, seen.trim_overflow);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (seen.out_byte !== want.out_byte || seen.has_byte !== want.has_byte ||
              seen.is_last !== want.is_last || seen.trim_overflow !== want.trim_overflow) begin
            if (fail_count < REPORT_LIMIT)
              $display("%0t: mismatch expected byte=%h has=%b last=%b ovf=%b, got byte=%h has=%b last=%b ovf=%b",
                       $realtime, want.out_byte, want.has_byte, want.is_last,
                       want.trim_overflow, seen.out_byte, seen.has_byte, seen.is_last,
                       seen.trim_overflow);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_text_whitespace_normalizer_core.sv =====
`timescale 1ns / 1ps
// Top of the text whitespace normalizer bench: clock, reset, input requests and
// output stalls; the twn_checker instance judges the results.
// Depends on twn_pkg, twn_if, text_whitespace_normalizer_core and twn_checker.
module tb_text_whitespace_normalizer_core;
  import twn_pkg::*;

  localparam int ITEM_TARGET  = 480;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 64;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_t;
  typedef enum int {SEG_END, SEG_WORD, SEG_BREAKS, SEG_TRAIL, SEG_NOISE} seg_kind_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   results_owed;
  int   cycle_count = 0;
  int   burst_left;
  int   sent;

  twn_in_if  in_chan();
  twn_out_if out_chan();

  text_whitespace_normalizer_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  twn_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_text_whitespace_normalizer_core: FAIL");
      $finish;
    end
  end

  // Output stalls: free-running, random, or one ready cycle per period, switching often.
  initial begin : sink_stall
    rx_mode_t rx_mode;
    int       mode_left;
    int       phase;
    int       period;
    out_chan.ready = 1'b0;
    rx_mode        = RX_FREE;
    mode_left      = 0;
    phase          = 0;
    period         = 2;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(32, 256);
        period    = $urandom_range(2, 8);
        phase     = 0;
      end
      mode_left--;
      case (rx_mode)
        RX_FREE: out_chan.ready <= 1'b1;
        RX_RANDOM: out_chan.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_chan.ready <= (phase == 0);
          phase = (phase + 1) % period;
        end
      endcase
    end
  end

  // One input request; bursts of random length with random gaps between them.
  task automatic send_req(input logic [7:0] b, input logic eot);
    if (burst_left == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_chan.valid       <= 1'b1;
    in_chan.text_byte   <= b;
    in_chan.end_of_text <= eot;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  // One random piece of text: mostly words and line breaks, now and then a long
  // trailing run that fills the trim store, raw noise or an end of text.
  task automatic send_segment();
    seg_kind_t kind;
    int        pick;
    int        len;
    pick = $urandom_range(0, 99);
    if (pick < 5) kind = SEG_END;
    else if (pick < 52) kind = SEG_WORD;
    else if (pick < 82) kind = SEG_BREAKS;
    else if (pick < 86) kind = SEG_TRAIL;
    else kind = SEG_NOISE;
    case (kind)
      SEG_END: send_req(8'($urandom_range(0, 255)), 1'b1);
      SEG_WORD: begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          if ($urandom_range(0, 3) != 0) send_req(8'($urandom_range(33, 126)), 1'b0);
          else send_req(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      SEG_BREAKS: begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          case ($urandom_range(0, 4))
            0: send_req(SPACE_CHAR, 1'b0);
            1: send_req(LINE_FEED, 1'b0);
            2: send_req(CARRIAGE_RETURN, 1'b0);
            3: begin
              send_req(CARRIAGE_RETURN, 1'b0);
              send_req(LINE_FEED, 1'b0);
            end
            default: begin
              send_req(LINE_FEED, 1'b0);
              send_req(LINE_FEED, 1'b0);
            end
          endcase
        end
      end
      SEG_TRAIL: begin
        len = $urandom_range(33, 38);
        repeat (len) send_req(($urandom_range(0, 3) == 0) ? LINE_FEED : SPACE_CHAR, 1'b0);
      end
      default: send_req(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  initial begin
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.text_byte   = 8'h00;
    in_chan.end_of_text = 1'b0;
    burst_left          = 0;
    sent                = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // An empty text gives only the end marker.
    send_req(8'h00, 1'b1);
    // Line breaks before any data are dropped; a leading space goes out at once.
    send_req(LINE_FEED, 1'b0);
    send_req(CARRIAGE_RETURN, 1'b0);
    send_req(SPACE_CHAR, 1'b0);
    send_req(8'h41, 1'b0);
    // A carriage return and line feed pair becomes one line feed with no space owed.
    send_req(CARRIAGE_RETURN, 1'b0);
    send_req(LINE_FEED, 1'b0);
    send_req(8'h62, 1'b0);
    // A lone line feed owes a space; later feeds of a run are output as line feeds.
    send_req(LINE_FEED, 1'b0);
    send_req(8'h63, 1'b0);
    send_req(LINE_FEED, 1'b0);
    send_req(LINE_FEED, 1'b0);
    send_req(LINE_FEED, 1'b0);
    // A space settles an owed space by itself.
    send_req(SPACE_CHAR, 1'b0);
    // Zero and all-ones are ordinary data bytes.
    send_req(8'h00, 1'b0);
    send_req(8'hFF, 1'b0);
    // Trailing space and line feeds are dropped at the end of the text.
    send_req(SPACE_CHAR, 1'b0);
    send_req(LINE_FEED, 1'b0);
    send_req(LINE_FEED, 1'b0);
    send_req(8'hFF, 1'b1);

    while (sent < ITEM_TARGET) send_segment();
    send_req(8'($urandom_range(0, 255)), 1'b1);
    in_chan.valid <= 1'b0;

    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_text_whitespace_normalizer_core: PASS");
    end else begin
      $display("tb_text_whitespace_normalizer_core: FAIL");
    end
    $finish;
  end

endmodule
